// ===== hw/rtl/iibs_pkg.sv =====
// Shared types and constants for the integral image box sum core.
// No dependencies; imported by the core and the testbench.
package iibs_pkg;

  // Table entries, line sums and results all wrap modulo 2^VALUE_W
  localparam int VALUE_W = 21;
  localparam int PIXEL_IN_W = 8;
  localparam int CORNER_W = 6;
  localparam int CFG_W = 7;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 24;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic REG_LINE_LENGTH = 1'b0;
  localparam logic REG_LINE_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_WR,
    ST_Q1,
    ST_Q2,
    ST_Q3,
    ST_QF
  } state_t;

endpackage

// ===== hw/rtl/iibs_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// Read data holds when the port is idle or writing. No dependencies.
module iibs_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== hw/rtl/integral_image_box_sum_core.sv =====
// Integral image builder with rectangle-sum queries.
// Depends on iibs_pkg and iibs_ram.
//
// Load words (tuser 0) bring pixels in raster order; each returns the new
// summed-area entry, with tlast set on the final pixel of the image. Query
// words (tuser 1) return I(b,b) + I(a,a) - I(a,b corner col) - I(b row,a col)
// modulo 2^21. Everything lives in one single-port table RAM, so a load reads the
// entry above and then writes, and a query does four reads and a final subtract;
// the last step of either waits while the output register is held by out_tready.
// A new word is taken while the previous result still waits. The
// table is not cleared after reset: query only entries already loaded. A
// register write restarts loading at line 0, position 0.
module integral_image_box_sum_core
  import iibs_pkg::*;
#(
  parameter int MAX_LINE_LENGTH = 64,
  parameter int MAX_LINES = 64,
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel [7:0], row_a [13:8], col_a [19:14], row_b [25:20], col_b [31:26]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // cmd [0]
  input  logic                  in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // value [20:0], zero [23:21]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // is_query [0]
  output logic                  out_tuser,
  output logic                  out_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int DEPTH = MAX_LINES * MAX_LINE_LENGTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int POS_W = $clog2(MAX_LINE_LENGTH);
  localparam int LIDX_W = $clog2(MAX_LINES);
  localparam int LEN_W = $clog2(MAX_LINE_LENGTH + 1);
  localparam int CNT_W = $clog2(MAX_LINES + 1);
  localparam logic [PIXEL_IN_W-1:0] PIX_MASK = PIXEL_IN_W'((1 << PIXEL_BITS) - 1);

  function automatic logic [LEN_W-1:0] clamp_len(input logic [CFG_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (32'(v) > MAX_LINE_LENGTH) begin
      r = LEN_W'(MAX_LINE_LENGTH);
    end else begin
      r = LEN_W'(v);
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (32'(v) > MAX_LINES) begin
      r = CNT_W'(MAX_LINES);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [LIDX_W-1:0] line,
                                                input logic [POS_W-1:0] pos);
    return ADDR_W'(line) * ADDR_W'(MAX_LINE_LENGTH) + ADDR_W'(pos);
  endfunction

  // corner outside the table reads as zero
  function automatic logic corner_oob(input logic [CORNER_W-1:0] row,
                                      input logic [CORNER_W-1:0] col);
    return (32'(row) >= MAX_LINES) || (32'(col) >= MAX_LINE_LENGTH);
  endfunction

  function automatic logic [ADDR_W-1:0] corner_addr(input logic [CORNER_W-1:0] row,
                                                    input logic [CORNER_W-1:0] col);
    return addr_of(LIDX_W'(row), POS_W'(col));
  endfunction

  // input fields
  logic [PIXEL_IN_W-1:0] in_pixel;
  logic [CORNER_W-1:0]   in_row_a, in_col_a, in_row_b, in_col_b;
  assign in_pixel = in_tdata[7:0];
  assign in_row_a = in_tdata[13:8];
  assign in_col_a = in_tdata[19:14];
  assign in_row_b = in_tdata[25:20];
  assign in_col_b = in_tdata[31:26];

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]   line_length_r;
  logic [CNT_W-1:0]   line_count_r;
  logic [POS_W-1:0]   line_pos_r;
  logic [LIDX_W-1:0]  line_idx_r;
  logic [VALUE_W-1:0] line_sum_r;

  logic [ADDR_W-1:0]  wr_addr_r;
  logic [VALUE_W-1:0] ld_sum_r;
  logic               ld_done_r;
  logic [CORNER_W-1:0] row_a_r, col_a_r, row_b_r, col_b_r;
  logic [VALUE_W-1:0] acc_r;
  logic               rd_zero_r;

  logic               out_valid_r;
  logic [VALUE_W-1:0] out_value_r;
  logic               out_query_r;
  logic               out_done_r;

  logic               ram_en, ram_we, rd_zero_nxt, out_load;
  logic [ADDR_W-1:0]  ram_addr;
  logic [VALUE_W-1:0] ram_wdata, ram_rdata, rd_val;

  logic accept, slot_free, line_end, image_end;
  logic [VALUE_W-1:0] sum_inc;
  logic [LEN_W-1:0]   pos_inc;
  logic [CNT_W-1:0]   idx_inc;

  assign accept = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign rd_val = rd_zero_r ? '0 : ram_rdata;

  assign sum_inc = line_sum_r + VALUE_W'(in_pixel & PIX_MASK);
  assign pos_inc = LEN_W'(line_pos_r) + LEN_W'(1);
  assign idx_inc = CNT_W'(line_idx_r) + CNT_W'(1);
  assign line_end = pos_inc >= line_length_r;
  assign image_end = line_end && (idx_inc >= line_count_r);

  iibs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_tuser == CMD_QUERY) ? ST_Q1 : ST_LD_WR;
        end
      end
      ST_LD_WR: if (slot_free) state_nxt = ST_IDLE;
      ST_Q1:    state_nxt = ST_Q2;
      ST_Q2:    state_nxt = ST_Q3;
      ST_Q3:    state_nxt = ST_QF;
      ST_QF:    if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // table port and result strobe
  always_comb begin
    in_tready = 1'b0;
    ram_en = 1'b0;
    ram_we = 1'b0;
    ram_addr = '0;
    ram_wdata = rd_val + ld_sum_r;
    rd_zero_nxt = rd_zero_r;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // hold off input while reset is asserted
        in_tready = rst_n;
        ram_en = accept;
        if (in_tuser == CMD_QUERY) begin
          ram_addr = corner_addr(in_row_b, in_col_b);
          rd_zero_nxt = corner_oob(in_row_b, in_col_b);
        end else begin
          // entry above; line 0 has none
          ram_addr = addr_of(line_idx_r - LIDX_W'(1), line_pos_r);
          rd_zero_nxt = (line_idx_r == '0);
        end
      end
      ST_LD_WR: begin
        ram_en = slot_free;
        ram_we = 1'b1;
        ram_addr = wr_addr_r;
        out_load = slot_free;
      end
      ST_Q1: begin
        ram_en = 1'b1;
        ram_addr = corner_addr(row_a_r, col_a_r);
        rd_zero_nxt = corner_oob(row_a_r, col_a_r);
      end
      ST_Q2: begin
        ram_en = 1'b1;
        ram_addr = corner_addr(row_a_r, col_b_r);
        rd_zero_nxt = corner_oob(row_a_r, col_b_r);
      end
      ST_Q3: begin
        ram_en = 1'b1;
        ram_addr = corner_addr(row_b_r, col_a_r);
        rd_zero_nxt = corner_oob(row_b_r, col_a_r);
      end
      ST_QF: out_load = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      line_length_r <= LEN_W'(MAX_LINE_LENGTH);
      line_count_r <= CNT_W'(MAX_LINES);
      line_pos_r <= '0;
      line_idx_r <= '0;
      line_sum_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        if (cfg_addr == REG_LINE_LENGTH) begin
          line_length_r <= clamp_len(cfg_wdata);
        end else begin
          line_count_r <= clamp_cnt(cfg_wdata);
        end
        line_pos_r <= '0;
        line_idx_r <= '0;
        line_sum_r <= '0;
      end else if (accept && in_tuser == CMD_LOAD) begin
        // advance the raster position
        if (line_end) begin
          line_pos_r <= '0;
          line_sum_r <= '0;
          line_idx_r <= image_end ? '0 : line_idx_r + LIDX_W'(1);
        end else begin
          line_pos_r <= line_pos_r + POS_W'(1);
          line_sum_r <= sum_inc;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_en && !ram_we) begin
      rd_zero_r <= rd_zero_nxt;
    end
    if (accept) begin
      wr_addr_r <= addr_of(line_idx_r, line_pos_r);
      ld_sum_r <= sum_inc;
      ld_done_r <= image_end;
      row_a_r <= in_row_a;
      col_a_r <= in_col_a;
      row_b_r <= in_row_b;
      col_b_r <= in_col_b;
    end
    case (state_r)
      ST_Q1: acc_r <= rd_val;
      ST_Q2: acc_r <= acc_r + rd_val;
      ST_Q3: acc_r <= acc_r - rd_val;
      default: ;
    endcase
    if (out_load) begin
      if (state_r == ST_QF) begin
        out_value_r <= acc_r - rd_val;
        out_query_r <= 1'b1;
        out_done_r <= 1'b0;
      end else begin
        out_value_r <= ram_wdata;
        out_query_r <= 1'b0;
        out_done_r <= ld_done_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {(OUT_DATA_W - VALUE_W)'(0), out_value_r};
  assign out_tuser = out_query_r;
  assign out_tlast = out_done_r;

  // a query keeps in_tready low through states Q1 to QF after it is taken
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser == CMD_QUERY) |=>
      !in_tready ##1 !in_tready ##1 !in_tready ##1 !in_tready)
    else $error("query sequence let a word in early");

  a_pos_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    (LEN_W'(line_pos_r) < line_length_r) && (CNT_W'(line_idx_r) < line_count_r))
    else $error("raster position outside configured image");

  a_query_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_query_r) |-> !out_done_r)
    else $error("query result marked as end of image");

  a_image_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && state_r == ST_LD_WR && ld_done_r) |->
      (line_idx_r == '0 && line_pos_r == '0))
    else $error("end of image without wrap to line 0");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for integral_image_box_sum_core: loads pixel images and
// asks rectangle sums, predicting every result word. Depends on iibs_pkg and the core.
module tb_top
  import iibs_pkg::*;
;

  localparam int SIDE = 64;
  localparam int STALL_PCT = 8;
  localparam int TARGET_WORDS = 1400;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               is_query;
    logic               image_done;
  } box_result_t;

  // Predicts the summed-area table and the result word of every accepted word.
  class summed_area_tracker;
    logic [VALUE_W-1:0] sat [SIDE][SIDE];
    bit                 loaded [SIDE][SIDE];
    int                 run_sum;
    int                 col;
    int                 row;
    int                 len;
    int                 cnt;
    int                 errors;
    box_result_t        pending_sums[$];

    function new();
      len = SIDE;
      cnt = SIDE;
      errors = 0;
      restart();
    endfunction

    function void restart();
      run_sum = 0;
      col = 0;
      row = 0;
    endfunction

    function int clamp_dim(logic [CFG_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > SIDE) return SIDE;
      return raw;
    endfunction

    function void write_reg(logic addr, logic [CFG_W-1:0] raw);
      if (addr == REG_LINE_LENGTH) len = clamp_dim(raw);
      else cnt = clamp_dim(raw);
      restart();
    endfunction

    function bit corners_loaded(int ra, int ca, int rb, int cb);
      return loaded[ra][ca] && loaded[rb][cb] && loaded[ra][cb] && loaded[rb][ca];
    endfunction

    function void take_word(logic cmd, logic [IN_DATA_W-1:0] data);
      box_result_t        r;
      int                 ra, ca, rb, cb;
      logic [VALUE_W-1:0] above;
      if (cmd == CMD_QUERY) begin
        ra = data[13:8];
        ca = data[19:14];
        rb = data[25:20];
        cb = data[31:26];
        // 21-bit context: wraps like the hardware
        r.value = sat[rb][cb] + sat[ra][ca] - sat[ra][cb] - sat[rb][ca];
        r.is_query = 1'b1;
        r.image_done = 1'b0;
      end else begin
        run_sum += data[PIXEL_IN_W-1:0];
        above = (row > 0) ? sat[row-1][col] : '0;
        r.value = above + VALUE_W'(run_sum);
        sat[row][col] = r.value;
        loaded[row][col] = 1'b1;
        r.is_query = 1'b0;
        r.image_done = 1'b0;
        col++;
        if (col >= len) begin
          col = 0;
          run_sum = 0;
          row++;
          if (row >= cnt) begin
            row = 0;
            r.image_done = 1'b1;
          end
        end
      end
      pending_sums.push_back(r);
    endfunction

    function void check_word(logic [OUT_DATA_W-1:0] tdata, logic tuser, logic tlast);
      box_result_t want;
      if (pending_sums.size() == 0) begin
        $display("%0t: result word with none expected, actual value %0d",
                 $time, $signed(tdata[VALUE_W-1:0]));
        errors++;
        return;
      end
      want = pending_sums.pop_front();
      if (tdata[VALUE_W-1:0] !== want.value) begin
        $display("%0t: value mismatch, expected %0d, actual %0d", $time,
                 $signed(want.value), $signed(tdata[VALUE_W-1:0]));
        errors++;
      end
      if (tdata[OUT_DATA_W-1:VALUE_W] !== '0) begin
        $display("%0t: tdata padding mismatch, expected 0, actual %0h", $time,
                 tdata[OUT_DATA_W-1:VALUE_W]);
        errors++;
      end
      if (tuser !== want.is_query) begin
        $display("%0t: is_query mismatch, expected %0b, actual %0b", $time,
                 want.is_query, tuser);
        errors++;
      end
      if (tlast !== want.image_done) begin
        $display("%0t: image_done mismatch, expected %0b, actual %0b", $time,
                 want.image_done, tlast);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic                  cfg_addr = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  logic                  no_gaps = 1'b0;
  int                    words_sent = 0;
  int                    idle_cycles = 0;
  summed_area_tracker    board = new();

  integral_image_box_sum_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= rst_n && (no_gaps || $urandom_range(99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_word(out_tdata, out_tuser, out_tlast);
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic cmd, input logic [IN_DATA_W-1:0] data);
    if (!no_gaps && $urandom_range(99) < STALL_PCT) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 50);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
    board.take_word(cmd, data);
    words_sent++;
  endtask

  task automatic load_pixel(input logic [PIXEL_IN_W-1:0] pix);
    send_word(CMD_LOAD, {24'($urandom), pix});
  endtask

  task automatic ask_sum(input logic [CORNER_W-1:0] ra, ca, rb, cb);
    send_word(CMD_QUERY, {cb, rb, ca, ra, 8'($urandom)});
  endtask

  // Hold off until every result is back, then let the core go quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (board.pending_sums.size() != 0) @(negedge clk);
    @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic addr, input logic [CFG_W-1:0] raw);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= raw;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.write_reg(addr, raw);
  endtask

  // Pick corners whose four entries have all been written, else fall back to corner (0,0).
  task automatic random_query();
    int ra, ca, rb, cb, tries;
    bit whole;
    tries = 0;
    whole = ($urandom_range(3) == 0);
    do begin
      ra = whole ? $urandom_range(SIDE - 1) : $urandom_range(board.cnt - 1);
      rb = whole ? $urandom_range(SIDE - 1) : $urandom_range(board.cnt - 1);
      ca = whole ? $urandom_range(SIDE - 1) : $urandom_range(board.len - 1);
      cb = whole ? $urandom_range(SIDE - 1) : $urandom_range(board.len - 1);
      tries++;
    end while (!board.corners_loaded(ra, ca, rb, cb) && tries < 48);
    if (!board.corners_loaded(ra, ca, rb, cb)) begin
      ra = 0;
      ca = 0;
      rb = 0;
      cb = 0;
    end
    ask_sum(CORNER_W'(ra), CORNER_W'(ca), CORNER_W'(rb), CORNER_W'(cb));
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] len_raw, cnt_raw);
    int loads, image;
    write_reg(REG_LINE_LENGTH, len_raw);
    write_reg(REG_LINE_COUNT, cnt_raw);
    image = board.len * board.cnt;
    case ($urandom_range(3))
      0: loads = $urandom_range(1, image);
      1: loads = image + $urandom_range(1, image);
      default: loads = image;
    endcase
    while (loads > 0) begin
      if ($urandom_range(99) < 25) begin
        random_query();
      end else begin
        load_pixel(($urandom_range(9) == 0) ? 8'hFF : 8'($urandom));
        loads--;
      end
    end
  endtask

  initial begin
    int phase;
    logic [CFG_W-1:0] len_raw, cnt_raw;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset dimensions: part of line 0 only, so every sum is zero.
    load_pixel(8'hFF);
    load_pixel(8'h00);
    load_pixel(8'h80);
    ask_sum(6'd0, 6'd0, 6'd0, 6'd2);
    // Restart in the middle of a line, then a full 2 x 2 image and a wrap.
    write_reg(REG_LINE_LENGTH, 7'd2);
    load_pixel(8'h11);
    write_reg(REG_LINE_COUNT, 7'd2);
    repeat (4) load_pixel(8'hFF);
    load_pixel(8'h07);
    load_pixel(8'h09);
    ask_sum(6'd0, 6'd0, 6'd1, 6'd1);
    ask_sum(6'd1, 6'd1, 6'd0, 6'd0);
    ask_sum(6'd1, 6'd0, 6'd0, 6'd1);
    ask_sum(6'd0, 6'd2, 6'd0, 6'd0);

    phase = 0;
    while (words_sent < TARGET_WORDS) begin
      case (phase)
        0: run_phase(7'd0, 7'd127);
        1: run_phase(7'd127, 7'd1);
        2: run_phase(7'd64, 7'd0);
        3: run_phase(7'd1, 7'd64);
        4: begin
          no_gaps <= 1'b1;
          run_phase(7'd16, 7'd8);
          no_gaps <= 1'b0;
        end
        default: begin
          do begin
            len_raw = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(65, 127))
                                               : CFG_W'($urandom_range(0, 12));
            cnt_raw = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(65, 127))
                                               : CFG_W'($urandom_range(0, 12));
          end while (board.clamp_dim(len_raw) * board.clamp_dim(cnt_raw) > 192);
          run_phase(len_raw, cnt_raw);
        end
      endcase
      phase++;
    end

    in_tvalid <= 1'b0;
    while (board.pending_sums.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== integral_image_box_sum_core.f =====
hw/rtl/iibs_pkg.sv
hw/rtl/iibs_ram.sv
hw/rtl/integral_image_box_sum_core.sv
tb/tb_top.sv
